### sv/bgfs_pkg.sv
package bgfs_pkg;

  localparam int unsigned PeriodW = 20;
  localparam int unsigned EnergyW = 16;
  localparam int unsigned CostW   = 56;
  localparam int unsigned StepW   = 8;

  // register byte offsets
  localparam logic [3:0] RegCenter    = 4'h0;
  localparam logic [3:0] RegTolerance = 4'h4;
  localparam logic [3:0] RegPerSteps  = 4'h8;
  localparam logic [3:0] RegPhsSteps  = 4'hC;

  localparam logic [PeriodW-1:0] CenterRst = 20'd11008;
  localparam logic [StepW-1:0]   TolRst    = 8'd26;
  localparam logic [StepW-1:0]   StepsRst  = 8'd32;

  typedef struct packed {
    logic [PeriodW-1:0] center_period;
    logic [StepW-1:0]   tolerance;
    logic [StepW-1:0]   period_steps;
    logic [StepW-1:0]   phase_steps;
  } cfg_t;

  typedef struct packed {
    logic [PeriodW-1:0] best_period;
    logic [PeriodW-1:0] best_phase;
    logic [CostW-1:0]   best_cost;
    logic               found;
  } res_t;

  typedef struct packed {
    logic [EnergyW-1:0] onset_energy;
    logic               last;
  } smp_t;

endpackage

### sv/bgfs_if.sv
interface bgfs_if #(
  parameter type T = logic
);
  logic valid;
  logic ready;
  T     data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

### sv/bgfs_div.sv
// Restoring divider, one quotient bit per cycle.
module bgfs_div #(
  parameter int unsigned NumW = 40,
  parameter int unsigned DenW = 40
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            start_i,
  input  logic [NumW-1:0] num_i,
  input  logic [DenW-1:0] den_i,
  output logic            done_o,
  output logic [NumW-1:0] quo_o,
  output logic [DenW-1:0] rem_o
);

  localparam int unsigned CntW = $clog2(NumW + 1);

  logic [NumW-1:0] quo_q, quo_d;
  logic [DenW:0]   rem_q, rem_d;
  logic [DenW-1:0] den_q, den_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic            busy_q, busy_d;
  logic            done_q, done_d;
  logic [DenW:0]   trial;

  always_comb begin
    quo_d  = quo_q;
    rem_d  = rem_q;
    den_d  = den_q;
    cnt_d  = cnt_q;
    busy_d = busy_q;
    done_d = 1'b0;
    trial  = {rem_q[DenW-1:0], quo_q[NumW-1]};
    if (start_i) begin
      quo_d  = num_i;
      rem_d  = '0;
      den_d  = den_i;
      cnt_d  = CntW'(NumW);
      busy_d = 1'b1;
    end else if (busy_q) begin
      // shift in next dividend bit, subtract when it fits
      if (trial >= {1'b0, den_q}) begin
        rem_d = trial - {1'b0, den_q};
        quo_d = {quo_q[NumW-2:0], 1'b1};
      end else begin
        rem_d = trial;
        quo_d = {quo_q[NumW-2:0], 1'b0};
      end
      cnt_d = cnt_q - 1'b1;
      if (cnt_q == CntW'(1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    quo_q <= quo_d;
    rem_q <= rem_d;
    den_q <= den_d;
  end

  assign done_o = done_q;
  assign quo_o  = quo_q;
  assign rem_o  = rem_q[DenW-1:0];

endmodule

### sv/bgfs_regs.sv
// APB register file for the search settings.
module bgfs_regs (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  output bgfs_pkg::cfg_t cfg_o
);

  bgfs_pkg::cfg_t cfg_q;
  logic           wr;

  assign pready = 1'b1;
  assign wr     = psel & penable & pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.center_period <= bgfs_pkg::CenterRst;
      cfg_q.tolerance     <= bgfs_pkg::TolRst;
      cfg_q.period_steps  <= bgfs_pkg::StepsRst;
      cfg_q.phase_steps   <= bgfs_pkg::StepsRst;
    end else if (wr) begin
      case (paddr)
        bgfs_pkg::RegCenter:    cfg_q.center_period <= pwdata[19:0];
        bgfs_pkg::RegTolerance: cfg_q.tolerance     <= pwdata[7:0];
        bgfs_pkg::RegPerSteps:  cfg_q.period_steps  <= pwdata[7:0];
        bgfs_pkg::RegPhsSteps:  cfg_q.phase_steps   <= pwdata[7:0];
        default: ;
      endcase
    end
  end

  // read mux
  always_comb begin
    case (paddr)
      bgfs_pkg::RegCenter:    prdata = {12'd0, cfg_q.center_period};
      bgfs_pkg::RegTolerance: prdata = {24'd0, cfg_q.tolerance};
      bgfs_pkg::RegPerSteps:  prdata = {24'd0, cfg_q.period_steps};
      bgfs_pkg::RegPhsSteps:  prdata = {24'd0, cfg_q.phase_steps};
      default:                prdata = '0;
    endcase
  end

  assign cfg_o = cfg_q;

endmodule

### sv/beat_grid_fit_search.sv
// Beat grid fit search. Onset-energy samples are written one per cycle into an
// internal store of MAX_BINS entries; the sample marked last starts the search.
// No sample is taken while the search runs. A finished result waits in its output
// register while the next load comes in.
// Each candidate grid walks the store once. Every bin takes these steps:
// - two 37-bit divisions in a shared bit-serial divider (the bin offset
//   modulo the period, then the distance scaled to Q0.16 by the period),
// - a start step,
// - an accumulate step.
// Each period or phase candidate adds its own division. A search therefore
// walks about (sum over period candidates of ceil(P/256) + phase_steps) grids,
// plus a short setup. P is the candidate period in bins, Q12.8.
module beat_grid_fit_search #(
  parameter int unsigned MAX_BINS = 4096
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  bgfs_if.sink        smp_in,
  bgfs_if.source      res_out,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  localparam int unsigned AddrW = $clog2(MAX_BINS);
  localparam int unsigned CntW  = AddrW + 1;
  localparam int unsigned PW    = bgfs_pkg::PeriodW;
  // numerator wide enough for b*256 + period, k * span, or d << 16
  localparam int unsigned NumW  = (CntW + 9 > PW + 17) ? CntW + 9 : PW + 17;
  localparam int unsigned CW    = bgfs_pkg::CostW;

  typedef enum logic [10:0] {
    SLoad   = 11'b00000000001,
    SSpan   = 11'b00000000010,
    SSpan2  = 11'b00000000100,
    SPerDiv = 11'b00000001000,
    SCand   = 11'b00000010000,
    SRead   = 11'b00000100000,
    SModDiv = 11'b00001000000,
    SScale  = 11'b00010000000,
    SAcc    = 11'b00100000000,
    SNext   = 11'b01000000000,
    SOut    = 11'b10000000000
  } state_e;

  bgfs_pkg::cfg_t cfg;
  bgfs_regs u_regs (
    .clk_i, .rst_ni, .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready,
    .cfg_o(cfg)
  );

  state_e state_q, state_d;

  // onset store
  logic [bgfs_pkg::EnergyW-1:0] mem [MAX_BINS];
  logic [bgfs_pkg::EnergyW-1:0] rd_q;
  logic                         wr_en;
  logic [AddrW-1:0]             wr_addr, rd_addr;

  always_ff @(posedge clk_i) begin
    if (wr_en) mem[wr_addr] <= smp_in.data.onset_energy;
    rd_q <= mem[rd_addr];
  end

  logic [CntW-1:0] cnt_q, cnt_d;   // sample count
  logic [CntW-1:0] bin_q, bin_d;   // bin under evaluation
  logic            phase2_q, phase2_d;
  logic [PW:0]     lo_q, lo_d, hi_q, hi_d;
  logic [7:0]      k_q, k_d;       // candidate index
  logic [PW-1:0]   per_q, per_d, phs_q, phs_d;
  logic [PW-1:0]   bper_q, bper_d, bphs_q, bphs_d;
  logic [CW-1:0]   sum_q, sum_d, min_q, min_d;
  logic [16:0]     qd_q, qd_d;
  bgfs_pkg::res_t  res_q, res_d;
  logic            rvalid_q, rvalid_d;

  logic [7:0]      ps, fs;
  assign ps = (cfg.period_steps == 8'd0) ? 8'd1 : cfg.period_steps;
  assign fs = (cfg.phase_steps == 8'd0) ? 8'd1 : cfg.phase_steps;

  // shared divider
  logic            dv_start, dv_done;
  logic [NumW-1:0] dv_num, dv_quo;
  logic [PW:0]     dv_den, dv_rem;
  bgfs_div #(.NumW(NumW), .DenW(PW + 1)) u_div (
    .clk_i, .rst_ni, .start_i(dv_start), .num_i(dv_num), .den_i(dv_den),
    .done_o(dv_done), .quo_o(dv_quo), .rem_o(dv_rem)
  );

  logic [PW+8:0]   span_prod;
  logic [NumW-1:0] nval;
  logic [PW:0]     r, pr, beat_dist;
  logic [CW-1:0]   thresh;
  logic [32:0]     acc_prod;

  assign thresh = CW'(cnt_q) << 32;
  // n = b*256 - F made non-negative by adding P (F < P always)
  assign nval   = NumW'(bin_q) * NumW'(256) + NumW'(per_q) - NumW'(phs_q);
  assign r      = dv_rem;
  assign pr     = {1'b0, per_q} - r;
  assign beat_dist = (r < pr) ? r : pr;
  assign acc_prod  = 33'(qd_q) * 33'(rd_q);

  assign smp_in.ready  = (state_q == SLoad);
  assign res_out.valid = rvalid_q;
  assign res_out.data  = res_q;
  assign wr_addr       = cnt_q[AddrW-1:0];
  assign rd_addr       = bin_q[AddrW-1:0];

  always_comb begin
    state_d  = state_q;
    cnt_d    = cnt_q;
    bin_d    = bin_q;
    phase2_d = phase2_q;
    lo_d     = lo_q;
    hi_d     = hi_q;
    k_d      = k_q;
    per_d    = per_q;
    phs_d    = phs_q;
    bper_d   = bper_q;
    bphs_d   = bphs_q;
    sum_d    = sum_q;
    min_d    = min_q;
    qd_d     = qd_q;
    res_d    = res_q;
    rvalid_d = rvalid_q;
    wr_en    = 1'b0;
    dv_start = 1'b0;
    dv_num   = nval;
    dv_den   = {1'b0, per_q};
    span_prod = '0;
    if (res_out.ready) rvalid_d = 1'b0;
    case (state_q)
      SLoad: begin
        if (smp_in.valid && smp_in.ready) begin
          if (cnt_q < CntW'(MAX_BINS)) begin
            wr_en = 1'b1;
            cnt_d = cnt_q + 1'b1;
          end
          if (smp_in.data.last) state_d = SSpan;
        end
      end
      SSpan: begin
        span_prod = (PW + 9)'(cfg.center_period) * (PW + 9)'(9'd256 - {1'b0, cfg.tolerance});
        lo_d      = span_prod[PW+8:8];
        min_d     = thresh;
        bper_d    = cfg.center_period;
        bphs_d    = '0;
        phase2_d  = 1'b0;
        k_d       = '0;
        state_d   = SSpan2;
      end
      SSpan2: begin
        span_prod = (PW + 9)'(cfg.center_period) * (PW + 9)'(9'd256 + {1'b0, cfg.tolerance});
        hi_d      = (span_prod[PW+8:8] > (PW + 1)'({PW{1'b1}})) ?
                    (PW + 1)'({PW{1'b1}}) : span_prod[PW+8:8];
        state_d   = SCand;
        if (!(lo_q < hi_d)) begin
          phase2_d = 1'b1;
        end
      end
      SCand: begin
        // compute candidate: k*(hi-lo)/ps or k*P/fs
        if (!phase2_q && k_q == ps) begin
          phase2_d = 1'b1;
          k_d      = '0;
        end else if (phase2_q && (k_q == fs || bper_q == '0)) begin
          state_d = SOut;
        end else begin
          dv_start = 1'b1;
          dv_num   = phase2_q ? NumW'({8'd0, k_q} * (PW + 8)'(bper_q)) :
                                NumW'({8'd0, k_q} * (PW + 8)'(hi_q - lo_q));
          dv_den   = phase2_q ? (PW + 1)'(fs) : (PW + 1)'(ps);
          state_d  = SPerDiv;
        end
        if (!phase2_q && k_q == ps) begin
          min_d  = thresh;
          bphs_d = '0;
        end
      end
      SPerDiv: begin
        if (dv_done) begin
          if (phase2_q) begin
            per_d = bper_q;
            phs_d = dv_quo[PW-1:0];
          end else begin
            per_d = PW'(lo_q + (PW + 1)'(dv_quo));
            phs_d = '0;
          end
          k_d = k_q + 1'b1;
          if (!phase2_q && PW'(lo_q + (PW + 1)'(dv_quo)) == '0) begin
            state_d = SCand;
          end else begin
            sum_d   = '0;
            bin_d   = '0;
            state_d = SRead;
          end
        end
      end
      SRead: begin
        if (bin_q == cnt_q) begin
          state_d = SNext;
        end else begin
          dv_start = 1'b1;
          state_d  = SModDiv;
        end
      end
      SModDiv: begin
        if (dv_done) begin
          dv_start = 1'b1;
          dv_num   = NumW'({beat_dist, 16'd0});
          state_d  = SScale;
        end
      end
      SScale: begin
        if (dv_done) begin
          qd_d    = dv_quo[16:0];
          state_d = SAcc;
        end
      end
      SAcc: begin
        sum_d   = sum_q + CW'(acc_prod);
        bin_d   = bin_q + 1'b1;
        state_d = SRead;
      end
      SNext: begin
        if (sum_q < min_q) begin
          min_d  = sum_q;
          bper_d = per_q;
          bphs_d = phs_q;
        end
        // next whole phase of same period, else next candidate
        if (!phase2_q && ((PW + 1)'(phs_q) + (PW + 1)'(256)) < (PW + 1)'(per_q)) begin
          phs_d   = phs_q + PW'(256);
          sum_d   = '0;
          bin_d   = '0;
          state_d = SRead;
        end else begin
          state_d = SCand;
        end
      end
      SOut: begin
        if (!rvalid_q || res_out.ready) begin
          res_d.best_period = bper_q;
          res_d.best_phase  = bphs_q;
          res_d.best_cost   = min_q;
          res_d.found       = min_q < thresh;
          rvalid_d          = 1'b1;
          cnt_d             = '0;
          state_d           = SLoad;
        end
      end
      default: state_d = SLoad;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= SLoad;
      cnt_q    <= '0;
      rvalid_q <= 1'b0;
      phase2_q <= 1'b0;
      k_q      <= '0;
    end else begin
      state_q  <= state_d;
      cnt_q    <= cnt_d;
      rvalid_q <= rvalid_d;
      phase2_q <= phase2_d;
      k_q      <= k_d;
    end
  end

  always_ff @(posedge clk_i) begin
    bin_q  <= bin_d;
    lo_q   <= lo_d;
    hi_q   <= hi_d;
    per_q  <= per_d;
    phs_q  <= phs_d;
    bper_q <= bper_d;
    bphs_q <= bphs_d;
    sum_q  <= sum_d;
    min_q  <= min_d;
    qd_q   <= qd_d;
    res_q  <= res_d;
  end

endmodule
